[rtl/aaid_pkg.sv]
// ----------------------------------------------------------------------------
// aaid_pkg
// Types and constants that the area-average downscaler files share.
// ----------------------------------------------------------------------------
package aaid_pkg;

    // Request codes carried in req_type.
    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_DST_HEIGHT = 2'd3;

    localparam int CFG_DATA_W = 11;
    localparam int DIV_W      = 27;   // dividend and quotient width
    localparam int DVSR_W     = 11;   // divisor width
    localparam int WGT_W      = 20;   // weight width

    // Division selects, in the order the controller runs them.
    localparam logic [1:0] DIV_STEP_X = 2'd0;
    localparam logic [1:0] DIV_FULL_X = 2'd1;
    localparam logic [1:0] DIV_STEP_Y = 2'd2;
    localparam logic [1:0] DIV_FULL_Y = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [9:0] src_col;
        logic [8:0] src_row;
        logic [7:0] pixel_value;
        logic [9:0] dst_col;
        logic [8:0] dst_row;
    } t_in_word;

    typedef struct packed {
        logic [23:0] weighted_sum;
        logic [9:0]  res_col;
        logic [8:0]  res_row;
    } t_out_word;

    typedef struct packed {
        logic       ram_write;
        logic       req_latch;
        logic       div_start;
        logic       div_store;
        logic [1:0] div_sel;
        logic       mul_setup;
        logic       wgt_mul;
        logic       wgt_sub;
        logic       y_init;
        logic       x_init;
        logic       pix_issue;
        logic       y_adv;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic zero_cfg;
        logic x_valid;
        logic y_valid;
        logic pipe_empty;
        logic out_free;
    } t_status;

endpackage

[rtl/area_average_image_downscaler.sv]
// ----------------------------------------------------------------------------
// area_average_image_downscaler
// Frame store with an area-averaging downscale of one destination pixel per
// compute request.
// ----------------------------------------------------------------------------
// A write word stores one luma pixel; writes can follow each other every
// cycle while no compute word holds the block. A compute word returns the
// weighted sum of its source window. The block accepts it, runs the four
// per-axis divisions in the shared one-bit-per-cycle divider and sets up
// both axes, then for each window row makes a row start, one read per
// nonzero-weight pixel (the frame store has a single read port) and a row
// advance, then closes the window walk, drains the pipeline and loads the
// result. The result sits in an output register, so the next word is taken
// while a result still waits. The user must write configuration only while
// the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module area_average_image_downscaler #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  aaid_pkg::t_in_word               i_in_word,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output aaid_pkg::t_out_word              o_out_word,
    input  logic                             i_out_stall,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [aaid_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import aaid_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    aaid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_word.req_type),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    aaid_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

[rtl/aaid_ram.sv]
// ----------------------------------------------------------------------------
// aaid_ram
// Single-port RAM with one write or read per cycle and registered read data.
// ----------------------------------------------------------------------------
module aaid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/aaid_div.sv]
// ----------------------------------------------------------------------------
// aaid_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aaid_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [aaid_pkg::DIV_W-1:0]    i_dividend,
    input  logic [aaid_pkg::DVSR_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [aaid_pkg::DIV_W-1:0]    o_quotient
);

    import aaid_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DVSR_W-1:0]  r_rem;
    logic [DVSR_W-1:0]  r_dvsr;
    logic [DIV_W-1:0]   r_quo;
    logic [DVSR_W:0]    w_trial;
    logic [DVSR_W:0]    w_diff;
    logic               w_qbit;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvsr};
    assign w_qbit  = (w_trial >= {1'b0, r_dvsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvsr <= i_divisor;
            r_quo  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_qbit ? w_diff[DVSR_W-1:0] : w_trial[DVSR_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_qbit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/aaid_datapath.sv]
// ----------------------------------------------------------------------------
// aaid_datapath
// Configuration, axis setup, weight generators, frame store and the
// multiply-accumulate pipeline of the downscaler.
// ----------------------------------------------------------------------------
module aaid_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  aaid_pkg::t_cmd                     i_cmd,
    output aaid_pkg::t_status                  o_status,
    input  aaid_pkg::t_in_word                 i_in_word,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [aaid_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_out_valid,
    output aaid_pkg::t_out_word                o_out_word,
    input  logic                               i_out_stall
);

    import aaid_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int YB    = $clog2(MAX_HEIGHT);
    localparam int POS_W = 23;
    localparam logic [POS_W-1:0] LIM_X = POS_W'(MAX_WIDTH);
    localparam logic [POS_W-1:0] LIM_Y = POS_W'(MAX_HEIGHT);

    typedef struct packed {
        logic [WGT_W-1:0] w;
        logic [21:0]      rem;
    } t_gen;

    // One step of the weight sequence: full while the remainder allows,
    // then what is left, then zero.
    function automatic t_gen gen_next(input logic [21:0] rem, input logic [WGT_W-1:0] full);
        t_gen g;
        logic signed [21:0] rs;
        logic signed [21:0] fs;
        rs = $signed(rem);
        fs = $signed({2'b00, full});
        if (rs >= fs) begin
            g.w   = full;
            g.rem = rem - {2'b00, full};
        end else if (rs > 22'sd0) begin
            g.w   = rem[WGT_W-1:0];
            g.rem = rem - {2'b00, full};
        end else begin
            g.w   = '0;
            g.rem = rem;
        end
        return g;
    endfunction

    // Configuration registers.
    logic [10:0] r_src_w;
    logic [9:0]  r_src_h;
    logic [10:0] r_dst_w;
    logic [9:0]  r_dst_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= 11'd640;
            r_src_h <= 10'd360;
            r_dst_w <= 11'd640;
            r_dst_h <= 10'd360;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data[9:0];
                CFG_DST_WIDTH:  r_dst_w <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_h <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Request fields.
    logic [9:0] r_col;
    logic [8:0] r_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_latch) begin
            r_col <= i_in_word.dst_col;
            r_row <= i_in_word.dst_row;
        end
    end

    // Divider and the axis setup.
    logic [DIV_W-1:0]  w_dividend;
    logic [DVSR_W-1:0] w_divisor;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_quo;
    logic [27:0]       w_round;
    logic [WGT_W-1:0]  w_full;

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_STEP_X: begin
                w_dividend = {r_src_w, 16'd0};
                w_divisor  = r_dst_w;
            end
            DIV_FULL_X: begin
                w_dividend = {r_dst_w, 16'd0};
                w_divisor  = r_src_w;
            end
            DIV_STEP_Y: begin
                w_dividend = {1'b0, r_src_h, 16'd0};
                w_divisor  = {1'b0, r_dst_h};
            end
            default: begin
                w_dividend = {1'b0, r_dst_h, 16'd0};
                w_divisor  = {1'b0, r_src_h};
            end
        endcase
    end

    aaid_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_round = {1'b0, w_quo} + 28'd128;
    assign w_full  = w_round[27:8];

    logic [DIV_W-1:0] r_step_x;
    logic [DIV_W-1:0] r_step_y;
    logic [WGT_W-1:0] r_full_x;
    logic [WGT_W-1:0] r_full_y;
    logic [36:0]      r_start_x;
    logic [36:0]      r_start_y;
    logic [11:0]      r_nx;
    logic [11:0]      r_ny;
    logic [35:0]      r_fm_x;
    logic [35:0]      r_fm_y;
    logic [WGT_W-1:0] r_w0x;
    logic [WGT_W-1:0] r_w0y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            unique case (i_cmd.div_sel)
                DIV_STEP_X: r_step_x <= w_quo;
                DIV_FULL_X: r_full_x <= w_full;
                DIV_STEP_Y: r_step_y <= w_quo;
                default:    r_full_y <= w_full;
            endcase
        end
        if (i_cmd.mul_setup) begin
            r_start_x <= 37'(r_col) * 37'(r_step_x);
            r_start_y <= 37'(r_row) * 37'(r_step_y);
            // A whole horizontal step trims the window to the step itself.
            if (r_step_x[15:0] == 16'd0) begin
                r_nx <= {1'b0, r_step_x[26:16]};
            end else begin
                r_nx <= {1'b0, r_step_x[26:16]} + 12'd2;
            end
            r_ny <= {1'b0, r_step_y[26:16]} + 12'd2;
        end
        if (i_cmd.wgt_mul) begin
            r_fm_x <= 36'(r_start_x[15:0]) * 36'(r_full_x);
            r_fm_y <= 36'(r_start_y[15:0]) * 36'(r_full_y);
        end
        if (i_cmd.wgt_sub) begin
            r_w0x <= r_full_x - r_fm_x[35:16];
            r_w0y <= r_full_y - r_fm_y[35:16];
        end
    end

    // Weight generators for both axes.
    logic [11:0]      r_kx, r_ky;
    logic [WGT_W-1:0] r_wx, r_wy;
    logic [21:0]      r_remx, r_remy;
    logic             r_vx, r_vy;
    logic [POS_W-1:0] r_px, r_py;
    t_gen             w_gx, w_gy;
    logic [11:0]      w_nkx, w_nky;

    assign w_gx  = gen_next(r_remx, r_full_x);
    assign w_gy  = gen_next(r_remy, r_full_y);
    assign w_nkx = r_kx + 12'd1;
    assign w_nky = r_ky + 12'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx <= 1'b0;
            r_vy <= 1'b0;
        end else begin
            if (i_cmd.x_init) begin
                r_vx <= (r_nx != 12'd0) && (r_w0x != '0);
            end else if (i_cmd.pix_issue) begin
                r_vx <= (w_nkx < r_nx) && (w_gx.w != '0);
            end
            if (i_cmd.y_init) begin
                r_vy <= (r_ny != 12'd0) && (r_w0y != '0);
            end else if (i_cmd.y_adv) begin
                r_vy <= (w_nky < r_ny) && (w_gy.w != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.x_init) begin
            r_kx   <= '0;
            r_wx   <= r_w0x;
            r_remx <= 22'd256 - {2'b00, r_w0x};
            r_px   <= {2'b00, r_start_x[36:16]};
        end else if (i_cmd.pix_issue) begin
            r_kx   <= w_nkx;
            r_wx   <= w_gx.w;
            r_remx <= w_gx.rem;
            r_px   <= r_px + 1'b1;
        end
        if (i_cmd.y_init) begin
            r_ky   <= '0;
            r_wy   <= r_w0y;
            r_remy <= 22'd256 - {2'b00, r_w0y};
            r_py   <= {2'b00, r_start_y[36:16]};
        end else if (i_cmd.y_adv) begin
            r_ky   <= w_nky;
            r_wy   <= w_gy.w;
            r_remy <= w_gy.rem;
            r_py   <= r_py + 1'b1;
        end
    end

    // Frame store.
    logic          w_wr_ok;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_addr;
    logic [7:0]    w_rdata;
    logic          w_outside;

    assign w_wr_ok = (32'(i_in_word.src_col) < 32'(MAX_WIDTH))
                  && (32'(i_in_word.src_row) < 32'(MAX_HEIGHT));
    assign w_we    = i_cmd.ram_write && w_wr_ok;
    assign w_waddr = AW'(i_in_word.src_row) * AW'(MAX_WIDTH) + AW'(i_in_word.src_col);
    assign w_raddr = AW'(r_py[YB-1:0]) * AW'(MAX_WIDTH) + AW'(r_px[XB-1:0]);
    assign w_addr  = i_cmd.ram_write ? w_waddr : w_raddr;

    // Pixels beyond the frame or the store count as zero.
    assign w_outside = (r_px >= {12'd0, r_src_w}) || (r_px >= LIM_X)
                    || (r_py >= {13'd0, r_src_h}) || (r_py >= LIM_Y);

    aaid_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (i_in_word.pixel_value),
        .o_rdata (w_rdata)
    );

    // Multiply-accumulate pipeline: read, pixel times x weight, times y weight,
    // then a saturating add.
    logic             r_s0_v, r_s1_v, r_s2_v;
    logic             r_s0_zero;
    logic [WGT_W-1:0] r_s0_wx, r_s0_wy, r_s1_wy;
    logic [27:0]      r_p1;
    logic [47:0]      r_p2;
    logic [23:0]      r_acc;
    logic             r_sat;
    logic [7:0]       w_pix;
    logic [24:0]      w_sum;

    assign w_pix = r_s0_zero ? 8'd0 : w_rdata;
    assign w_sum = {1'b0, r_acc} + {1'b0, r_p2[23:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s0_v <= i_cmd.pix_issue;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_zero <= w_outside;
        r_s0_wx   <= r_wx;
        r_s0_wy   <= r_wy;
        r_p1      <= 28'(w_pix) * 28'(r_s0_wx);
        r_s1_wy   <= r_s0_wy;
        r_p2      <= 48'(r_p1) * 48'(r_s1_wy);
        if (i_cmd.req_latch) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (r_s2_v) begin
            r_acc <= w_sum[23:0];
            if ((r_p2[47:24] != '0) || w_sum[24]) begin
                r_sat <= 1'b1;
            end
        end
    end

    // Output register.
    logic      r_out_v;
    t_out_word r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_word.weighted_sum <= r_sat ? 24'hFFFFFF : r_acc;
            r_out_word.res_col      <= r_col;
            r_out_word.res_row      <= r_row;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out_word;

    assign o_status.div_done   = w_div_done;
    assign o_status.zero_cfg   = (r_src_w == '0) || (r_src_h == '0)
                              || (r_dst_w == '0) || (r_dst_h == '0);
    assign o_status.x_valid    = r_vx;
    assign o_status.y_valid    = r_vy;
    assign o_status.pipe_empty = !(r_s0_v || r_s1_v || r_s2_v);
    assign o_status.out_free   = !r_out_v || !i_out_stall;

endmodule

[rtl/aaid_ctrl.sv]
// ----------------------------------------------------------------------------
// aaid_ctrl
// Sequencer for one request: store write, or divisions, setup, window walk,
// pipeline drain and result hand-off.
// ----------------------------------------------------------------------------
module aaid_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_req_type,
    output logic               o_in_stall,
    input  aaid_pkg::t_status  i_status,
    output aaid_pkg::t_cmd     o_cmd
);

    import aaid_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIV_WAIT,
        ST_MUL,
        ST_WGT_MUL,
        ST_WGT_SUB,
        ST_Y_INIT,
        ST_ROW_START,
        ST_PIX,
        ST_DRAIN,
        ST_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_div_sel, n_div_sel;
    logic       w_accept;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_div_sel = r_div_sel;
        o_cmd     = '0;
        o_cmd.div_sel = r_div_sel;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_WRITE) begin
                        o_cmd.ram_write = 1'b1;
                    end else begin
                        o_cmd.req_latch = 1'b1;
                        n_div_sel       = DIV_STEP_X;
                        n_state         = i_status.zero_cfg ? ST_OUT : ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_div_sel == DIV_FULL_Y) begin
                        n_state = ST_MUL;
                    end else begin
                        n_div_sel = r_div_sel + 2'd1;
                        n_state   = ST_DIV;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul_setup = 1'b1;
                n_state         = ST_WGT_MUL;
            end
            ST_WGT_MUL: begin
                o_cmd.wgt_mul = 1'b1;
                n_state       = ST_WGT_SUB;
            end
            ST_WGT_SUB: begin
                o_cmd.wgt_sub = 1'b1;
                n_state       = ST_Y_INIT;
            end
            ST_Y_INIT: begin
                o_cmd.y_init = 1'b1;
                n_state      = ST_ROW_START;
            end
            ST_ROW_START: begin
                if (i_status.y_valid) begin
                    o_cmd.x_init = 1'b1;
                    n_state      = ST_PIX;
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_PIX: begin
                if (i_status.x_valid) begin
                    o_cmd.pix_issue = 1'b1;
                end else begin
                    o_cmd.y_adv = 1'b1;
                    n_state     = ST_ROW_START;
                end
            end
            ST_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_div_sel <= DIV_STEP_X;
        end else begin
            r_state   <= n_state;
            r_div_sel <= n_div_sel;
        end
    end

endmodule

[verif/tb_area_average_image_downscaler.sv]
// ----------------------------------------------------------------------------
// tb_area_average_image_downscaler
// Self-checking bench for the area-average downscaler. A directed table walks
// the field extremes and the identity setting after reset. Random phases then
// run many size settings: downscales, zero sizes, upscales that saturate, and
// the largest register values. Every window pixel is written before a compute
// word reads it. An in-bench predictor works out each weighted sum, and the
// results are compared in order with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_area_average_image_downscaler;
    import aaid_pkg::*;

    localparam int STORE_W   = 1024;
    localparam int STORE_H   = 512;
    localparam int WIN_MAX   = 2052;
    localparam int CYCLE_CAP = 4000000;
    localparam longint SUM_TOP = 64'hFFFFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_word    i_in_word = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_word   o_out_word;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_SRC_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    area_average_image_downscaler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow of the frame store and of the size registers.
    logic [7:0] luma_store [0:STORE_W*STORE_H-1];
    bit         luma_known [0:STORE_W*STORE_H-1];
    longint     src_w = 640, src_h = 360, dst_w = 640, dst_h = 360;

    longint     wgt_x [WIN_MAX];
    longint     wgt_y [WIN_MAX];
    longint     first_x, first_y;
    int         len_x, len_y;

    t_out_word  pending_sums [$];
    int         errors = 0;
    int         cycles = 0;
    bit         calm = 1'b0;

    // Builds the start pixel and the weight run of one axis.
    function automatic void build_axis(bit is_x, longint idx);
        longint src, dst, step, full, start, frac, rem, w0;
        int     n;
        src  = is_x ? src_w : src_h;
        dst  = is_x ? dst_w : dst_h;
        step = (src << 16) / dst;
        full = (((dst << 16) / src) + 128) >> 8;
        n    = int'(step >> 16) + 2;
        if (is_x && (step & 64'hffff) == 0)
            n = int'(step >> 16);
        if (n > WIN_MAX)
            n = WIN_MAX;
        start = idx * step;
        frac  = start & 64'hffff;
        if (is_x) begin
            first_x = start >> 16;
            len_x = n;
        end else begin
            first_y = start >> 16;
            len_y = n;
        end
        if (n == 0)
            return;
        w0  = full - ((frac * full) >>> 16);
        rem = 256 - w0;
        if (is_x) wgt_x[0] = w0; else wgt_y[0] = w0;
        for (int k = 1; k < n; k++) begin
            longint w;
            if (rem >= full) begin
                w = full;
                rem -= full;
            end else if (rem > 0) begin
                w = rem;
                rem -= full;
            end else begin
                w = 0;
            end
            if (is_x) wgt_x[k] = w; else wgt_y[k] = w;
        end
    endfunction

    function automatic bit in_frame(longint row, longint col);
        return col < src_w && row < src_h && col < STORE_W && row < STORE_H;
    endfunction

    function automatic bit sizes_zero();
        return src_w == 0 || src_h == 0 || dst_w == 0 || dst_h == 0;
    endfunction

    function automatic logic [23:0] area_sum(longint col, longint row);
        longint total;
        total = 0;
        if (sizes_zero())
            return '0;
        build_axis(1'b1, col);
        build_axis(1'b0, row);
        for (int j = 0; j < len_y; j++) begin
            longint line;
            line = 0;
            if (wgt_y[j] == 0)
                continue;
            for (int i = 0; i < len_x; i++) begin
                if (wgt_x[i] != 0 && in_frame(first_y + j, first_x + i))
                    line += longint'(luma_store[(first_y + j) * STORE_W + first_x + i])
                            * wgt_x[i];
            end
            total += line * wgt_y[j];
            if (total > SUM_TOP)
                return 24'hFFFFFF;
        end
        return total[23:0];
    endfunction

    // Hands one word to the block and updates the shadow state in order.
    // Valid stays high after the handshake so that the next word can follow
    // at once; whoever waits next drops it.
    task automatic send_word(t_in_word w, bit typed, logic [23:0] typed_sum);
        t_out_word e;
        if (w.req_type == REQ_WRITE) begin
            luma_store[w.src_row * STORE_W + w.src_col] = w.pixel_value;
            luma_known[w.src_row * STORE_W + w.src_col] = 1'b1;
        end else begin
            e.weighted_sum = typed ? typed_sum : area_sum(w.dst_col, w.dst_row);
            e.res_col = w.dst_col;
            e.res_row = w.dst_row;
            pending_sums.push_back(e);
        end
        if (!calm && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_pixel(int col, int row, int value);
        t_in_word w;
        w = '0;
        w.req_type    = REQ_WRITE;
        w.src_col     = col[9:0];
        w.src_row     = row[8:0];
        w.pixel_value = value[7:0];
        w.dst_col     = 10'($urandom);
        w.dst_row     = 9'($urandom);
        send_word(w, 1'b0, '0);
    endtask

    // Writes every window pixel that a compute word would read but is unset.
    task automatic cover_window(longint col, longint row);
        if (sizes_zero())
            return;
        build_axis(1'b1, col);
        build_axis(1'b0, row);
        for (int j = 0; j < len_y; j++) begin
            if (wgt_y[j] == 0)
                continue;
            for (int i = 0; i < len_x; i++) begin
                longint r, c;
                r = first_y + j;
                c = first_x + i;
                if (wgt_x[i] != 0 && in_frame(r, c) && !luma_known[r * STORE_W + c])
                    write_pixel(int'(c), int'(r), $urandom_range(255));
            end
        end
    endtask

    task automatic compute_pixel(int col, int row, bit typed, logic [23:0] typed_sum);
        t_in_word w;
        cover_window(col, row);
        w = '0;
        w.req_type    = REQ_COMPUTE;
        w.src_col     = 10'($urandom);
        w.src_row     = 9'($urandom);
        w.pixel_value = 8'($urandom);
        w.dst_col     = col[9:0];
        w.dst_row     = row[8:0];
        send_word(w, typed, typed_sum);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Valid stays high between back-to-back register writes.
    task automatic write_reg(logic [1:0] idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SRC_WIDTH:  src_w = value & 'h7ff;
            CFG_SRC_HEIGHT: src_h = value & 'h3ff;
            CFG_DST_WIDTH:  dst_w = value & 'h7ff;
            CFG_DST_HEIGHT: dst_h = value & 'h3ff;
            default: ;
        endcase
    endtask

    task automatic set_sizes(int sw, int sh, int dw, int dh);
        drain();
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
        i_cfg_valid <= 1'b0;
    endtask

    // Random phase: mostly in-range compute words, with stray writes and
    // requests beyond the destination mixed in.
    task automatic run_phase(int count);
        for (int k = 0; k < count; k++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 25) begin
                if ($urandom_range(3) == 0)
                    write_pixel($urandom_range(1023), $urandom_range(511), $urandom_range(255));
                else
                    write_pixel($urandom_range(int'(src_w > 0 ? src_w - 1 : 0) % STORE_W),
                                $urandom_range(int'(src_h > 0 ? src_h - 1 : 0) % STORE_H),
                                $urandom_range(255));
            end else if (pick < 35) begin
                compute_pixel($urandom_range(1023), $urandom_range(511), 1'b0, '0);
            end else begin
                compute_pixel($urandom_range(int'(dst_w > 0 ? dst_w - 1 : 0) % STORE_W),
                              $urandom_range(int'(dst_h > 0 ? dst_h - 1 : 0) % STORE_H),
                              1'b0, '0);
            end
        end
    endtask

    typedef struct {
        bit          compute;
        int          col;
        int          row;
        int          value;
        bit          typed;
        logic [23:0] sum;
    } t_plan_row;

    t_plan_row plan [14];

    // Output stall, with the calm stretch free of stalls.
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 31);
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected word sum=%0d col=%0d row=%0d", $time,
                         o_out_word.weighted_sum, o_out_word.res_col, o_out_word.res_row);
                errors++;
            end else begin
                t_out_word e;
                e = pending_sums.pop_front();
                if (o_out_word.weighted_sum !== e.weighted_sum) begin
                    $display("%0t: weighted_sum expected %0d actual %0d", $time,
                             e.weighted_sum, o_out_word.weighted_sum);
                    errors++;
                end
                if (o_out_word.res_col !== e.res_col) begin
                    $display("%0t: res_col expected %0d actual %0d", $time,
                             e.res_col, o_out_word.res_col);
                    errors++;
                end
                if (o_out_word.res_row !== e.res_row) begin
                    $display("%0t: res_row expected %0d actual %0d", $time,
                             e.res_row, o_out_word.res_row);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("area_average_image_downscaler regression: fail");
            $finish;
        end
    end

    initial begin
        int sent;
        int phase;
        plan[0]  = '{1'b0,    0,   0, 255, 1'b0, 24'd0};
        plan[1]  = '{1'b1,    0,   0,   0, 1'b1, 24'd16711680};
        plan[2]  = '{1'b0,  639, 359, 255, 1'b0, 24'd0};
        plan[3]  = '{1'b1,  639, 359,   0, 1'b1, 24'd16711680};
        plan[4]  = '{1'b0, 1023, 511, 170, 1'b0, 24'd0};
        plan[5]  = '{1'b1, 1023, 511,   0, 1'b1, 24'd0};
        plan[6]  = '{1'b0,    5,   5,   0, 1'b0, 24'd0};
        plan[7]  = '{1'b1,    5,   5,   0, 1'b1, 24'd0};
        plan[8]  = '{1'b0,    1,   0,  85, 1'b0, 24'd0};
        plan[9]  = '{1'b0,    0,   1,   1, 1'b0, 24'd0};
        plan[10] = '{1'b1,    1,   0,   0, 1'b0, 24'd0};
        plan[11] = '{1'b1,    0,   1,   0, 1'b0, 24'd0};
        plan[12] = '{1'b0,  512, 256,  90, 1'b0, 24'd0};
        plan[13] = '{1'b1,  512, 256,   0, 1'b0, 24'd0};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity sizes after reset: one source pixel per destination pixel.
        foreach (plan[n]) begin
            if (plan[n].compute)
                compute_pixel(plan[n].col, plan[n].row, plan[n].typed, plan[n].sum);
            else
                write_pixel(plan[n].col, plan[n].row, plan[n].value);
        end

        // Fixed corner settings: smallest, zero sizes, upscale, largest, full-store downscale.
        set_sizes(1, 1, 1, 1);
        run_phase(30);
        set_sizes(0, 9, 4, 4);
        run_phase(15);
        set_sizes(12, 9, 6, 0);
        run_phase(15);
        set_sizes(5, 4, 300, 200);
        write_pixel(0, 0, 255);
        run_phase(50);
        set_sizes(2047, 1023, 2047, 1023);
        run_phase(40);
        set_sizes(1024, 512, 1000, 500);
        run_phase(60);

        // Window cover writes come on top of the phase words.
        sent = 0;
        phase = 0;
        while (sent < 960) begin
            int sw, sh;
            sw = $urandom_range(1, 40);
            sh = $urandom_range(1, 32);
            set_sizes(sw, sh, $urandom_range((sw + 7) / 8, sw), $urandom_range((sh + 7) / 8, sh));
            calm = (phase == 3);
            run_phase(120);
            calm = 1'b0;
            sent += 120;
            phase++;
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("area_average_image_downscaler regression: pass");
        else
            $display("area_average_image_downscaler regression: fail");
        $finish;
    end
endmodule
